// ----- rtl/rthsv_pkg.sv -----
`default_nettype none

package rthsv_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned QBits     = 8;
  localparam int unsigned NumW      = 16;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [8:0] HueRedBase   = 9'd0;
  localparam logic [8:0] HueGreenBase = 9'd120;
  localparam logic [8:0] HueBlueBase  = 9'd240;
  localparam logic [8:0] HueWrap      = 9'd360;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // Classified pixel as it leaves the front part.
  typedef struct packed {
    logic [PixW-1:0] hi;
    logic [PixW-1:0] delta;
    logic [PixW-1:0] abs_diff;
    logic            neg;
    sector_e         sector;
  } cls_t;

  // One beat inside the divider pipeline of the back part.
  typedef struct packed {
    logic [NumW-1:0]  r_sat;
    logic [NumW-1:0]  r_hue;
    logic [PixW-1:0]  d_sat;
    logic [PixW-1:0]  d_hue;
    logic [QBits-1:0] q_sat;
    logic [QBits-1:0] q_hue;
    logic             neg;
    sector_e          sector;
  } pipe_t;

  function automatic pipe_t div_step(pipe_t p, logic [2:0] bit_idx);
    pipe_t           n;
    logic [NumW-1:0] sh_sat;
    logic [NumW-1:0] sh_hue;
    n      = p;
    sh_sat = NumW'(p.d_sat) << bit_idx;
    sh_hue = NumW'(p.d_hue) << bit_idx;
    if (p.r_sat >= sh_sat) begin
      n.r_sat          = p.r_sat - sh_sat;
      n.q_sat[bit_idx] = 1'b1;
    end
    if (p.r_hue >= sh_hue) begin
      n.r_hue          = p.r_hue - sh_hue;
      n.q_hue[bit_idx] = 1'b1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rthsv_front.sv -----
`default_nettype none

module rthsv_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  output logic                          full_o,
  input  wire logic [rthsv_pkg::PixW-1:0] red_i,
  input  wire logic [rthsv_pkg::PixW-1:0] green_i,
  input  wire logic [rthsv_pkg::PixW-1:0] blue_i,
  output logic                          q_push_o,
  input  wire logic                     q_full_i,
  output rthsv_pkg::cls_t               q_data_o
);
  import rthsv_pkg::*;

  logic        vld_q, vld_d;
  cls_t        cls_q, cls_d;
  logic        accept;
  logic [PixW-1:0] hi, lo;
  logic signed [PixW:0] diff;

  assign q_push_o = vld_q && !q_full_i;
  assign full_o   = vld_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_data_o = cls_q;

  always_comb begin
    hi = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i > hi) hi = blue_i;
    lo = red_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo) lo = blue_i;

    if (red_i == hi) begin
      cls_d.sector = SEC_RED;
      diff = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i == hi) begin
      cls_d.sector = SEC_GREEN;
      diff = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      cls_d.sector = SEC_BLUE;
      diff = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end

    cls_d.hi       = hi;
    cls_d.delta    = hi - lo;
    cls_d.neg      = diff[PixW];
    cls_d.abs_diff = diff[PixW] ? PixW'(-diff) : PixW'(diff);

    if (accept) begin
      vld_d = 1'b1;
    end else if (q_push_o) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q <= cls_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rthsv_fifo.sv -----
`default_nettype none

module rthsv_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rthsv_pkg::cls_t wdata_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output rthsv_pkg::cls_t      rdata_o,
  output logic                 empty_o
);
  import rthsv_pkg::*;

  cls_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rthsv_back.sv -----
`default_nettype none

module rthsv_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rthsv_pkg::cls_t            q_data_i,
  input  wire logic                       q_empty_i,
  output logic                            q_pop_o,
  output logic                            empty_o,
  input  wire logic                       pop_i,
  output logic [rthsv_pkg::PixW-1:0]      hue_o,
  output logic [rthsv_pkg::PixW-1:0]      saturation_o,
  output logic [rthsv_pkg::PixW-1:0]      brightness_o
);
  import rthsv_pkg::*;

  pipe_t            st_q [QBits+1];
  logic [QBits:0]   vld_q;
  pipe_t            load;
  logic             adv;
  logic             out_vld_q;
  logic [PixW-1:0]  hue_q, sat_q, bri_q;
  logic [PixW-1:0]  hue_d, sat_d;
  logic [8:0]       base, deg;
  pipe_t            last;

  // The whole pipeline moves one step whenever the output register is free
  // or being drained.
  assign adv     = !out_vld_q || pop_i;
  assign q_pop_o = adv && !q_empty_i;
  assign empty_o = !out_vld_q;
  assign last    = st_q[QBits];

  always_comb begin
    load.r_sat  = {q_data_i.delta, 8'd0} - NumW'(q_data_i.delta);
    load.r_hue  = (NumW'(q_data_i.abs_diff) << 6) - (NumW'(q_data_i.abs_diff) << 2);
    load.d_sat  = q_data_i.hi;
    load.d_hue  = q_data_i.delta;
    load.q_sat  = '0;
    load.q_hue  = '0;
    load.neg    = q_data_i.neg;
    load.sector = q_data_i.sector;
  end

  always_comb begin
    unique case (last.sector)
      SEC_RED:   base = (last.neg && last.q_hue != '0) ? HueWrap : HueRedBase;
      SEC_GREEN: base = HueGreenBase;
      SEC_BLUE:  base = HueBlueBase;
      default:   base = HueRedBase;
    endcase
    if (last.neg) begin
      deg = base - 9'(last.q_hue);
    end else begin
      deg = base + 9'(last.q_hue);
    end
    hue_d = (last.d_hue == '0) ? '0 : deg[8:1];
    sat_d = (last.d_sat == '0) ? '0 : last.q_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[QBits-1:0], !q_empty_i};
      out_vld_q <= vld_q[QBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= load;
      for (int k = 0; k < QBits; k++) begin
        st_q[k+1] <= div_step(st_q[k], 3'(QBits - 1 - k));
      end
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= last.d_sat;
    end
  end

  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bri_q;

endmodule

`default_nettype wire

// ----- rtl/rgb_to_hsv_8bit.sv -----
`default_nettype none

// Channel  Direction  Handshake     Beat contents
// pixel    in         push / full   red_i, green_i, blue_i
// hsv      out        empty / pop   hue_o, saturation_o, brightness_o
//
// One beat is taken per cycle while full is low. An accepted pixel passes
// through the front register, the queue, the eight-step shared divider pipeline
// that yields both quotients one bit per stage, and the output register.
// Reset clears all valid flags and the queue; no clearing pass is needed.
// With pop held low the back pipeline freezes once its output is valid, the
// four-entry queue fills and then full rises after the front register is occupied.

module rgb_to_hsv_8bit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [rthsv_pkg::PixW-1:0]  red_i,
  input  wire logic [rthsv_pkg::PixW-1:0]  green_i,
  input  wire logic [rthsv_pkg::PixW-1:0]  blue_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [rthsv_pkg::PixW-1:0]       hue_o,
  output logic [rthsv_pkg::PixW-1:0]       saturation_o,
  output logic [rthsv_pkg::PixW-1:0]       brightness_o
);
  import rthsv_pkg::*;

  cls_t f_data, q_data;
  logic f_push, f_full, q_empty, q_pop;

  rthsv_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .red_i    (red_i),
    .green_i  (green_i),
    .blue_i   (blue_i),
    .q_push_o (f_push),
    .q_full_i (f_full),
    .q_data_o (f_data)
  );

  rthsv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_data),
    .full_o  (f_full),
    .pop_i   (q_pop),
    .rdata_o (q_data),
    .empty_o (q_empty)
  );

  rthsv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_data_i     (q_data),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> hue_o <= 8'd179)
    else $error("hue beyond half-scale range");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && brightness_o == '0) |-> (saturation_o == '0 && hue_o == '0))
    else $error("black pixel with nonzero hue or saturation");

  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && saturation_o == '0) |-> hue_o == '0)
    else $error("gray pixel with nonzero hue");

endmodule

`default_nettype wire
